### rtl/apt_pkg.sv
`default_nettype none
package apt_pkg;

	// Fixed-point format of the point coordinates and the coefficients
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int COEF_BITS  = 32;

	// Full-precision product, accumulator with headroom for three products
	// plus translation and rounding term
	localparam int PROD_BITS = COEF_BITS + COORD_BITS;
	localparam int ACC_BITS  = PROD_BITS + 2;

	localparam int NUM_ROWS      = 3;
	localparam int NUM_REGS      = 6;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_ADDR_BITS = 6;
	localparam int REG_IDX_BITS  = 3;

	// Register indexes (byte address is 8 * index)
	localparam logic [REG_IDX_BITS-1:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW2_COLS01 = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW2_COLS23 = 3'd5;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COEF_BITS-1:0]  coef_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	// Half an output LSB; zero when there are no fraction bits
	localparam acc_t ROUND_HALF = ACC_BITS'((1 << FRAC_BITS) >> 1);

	typedef struct packed {
		coord_t in_x;
		coord_t in_y;
		coord_t in_z;
		logic   last_in;
	} point_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   saturated;
		logic   last_out;
	} result_t;

	typedef struct packed {
		coef_t c0;
		coef_t c1;
		coef_t c2;
		coef_t tr;
	} row_coef_t;

	typedef row_coef_t [NUM_ROWS-1:0] matrix_t;

	typedef struct packed {
		prod_t p0;
		prod_t p1;
		prod_t p2;
	} row_prod_t;

endpackage
`default_nettype wire

### rtl/apt_cfg_regs.sv
`default_nettype none
module apt_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [apt_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  wire logic [apt_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic      [apt_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                     pready,
	output apt_pkg::matrix_t                         matrix
);

	localparam logic [apt_pkg::CFG_DATA_BITS-1:0] RESET_VAL [apt_pkg::NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};
	localparam logic [apt_pkg::REG_IDX_BITS-1:0] LAST_IDX =
		apt_pkg::REG_IDX_BITS'(apt_pkg::NUM_REGS - 1);

	logic [apt_pkg::CFG_DATA_BITS-1:0] reg_q [apt_pkg::NUM_REGS];
	logic [apt_pkg::REG_IDX_BITS-1:0]  idx;
	logic                              wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[apt_pkg::CFG_ADDR_BITS-1:3];
	assign wr_en  = psel && penable && pwrite && pready;

	// Drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < apt_pkg::NUM_REGS; i++) begin
				reg_q[i] <= RESET_VAL[i];
			end
		end else if (wr_en && idx <= LAST_IDX) begin
			reg_q[idx] <= pwdata;
		end
	end

	always_comb begin
		if (idx <= LAST_IDX) begin
			prdata = reg_q[idx];
		end else begin
			prdata = '0;
		end
	end

	// Even column in the low half, odd column in the high half
	always_comb begin
		matrix[0].c0 = reg_q[apt_pkg::REG_ROW0_COLS01][31:0];
		matrix[0].c1 = reg_q[apt_pkg::REG_ROW0_COLS01][63:32];
		matrix[0].c2 = reg_q[apt_pkg::REG_ROW0_COLS23][31:0];
		matrix[0].tr = reg_q[apt_pkg::REG_ROW0_COLS23][63:32];
		matrix[1].c0 = reg_q[apt_pkg::REG_ROW1_COLS01][31:0];
		matrix[1].c1 = reg_q[apt_pkg::REG_ROW1_COLS01][63:32];
		matrix[1].c2 = reg_q[apt_pkg::REG_ROW1_COLS23][31:0];
		matrix[1].tr = reg_q[apt_pkg::REG_ROW1_COLS23][63:32];
		matrix[2].c0 = reg_q[apt_pkg::REG_ROW2_COLS01][31:0];
		matrix[2].c1 = reg_q[apt_pkg::REG_ROW2_COLS01][63:32];
		matrix[2].c2 = reg_q[apt_pkg::REG_ROW2_COLS23][31:0];
		matrix[2].tr = reg_q[apt_pkg::REG_ROW2_COLS23][63:32];
	end

endmodule
`default_nettype wire

### rtl/apt_row_mul.sv
`default_nettype none
module apt_row_mul (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire apt_pkg::row_coef_t  coef,
	input  wire apt_pkg::point_t     pt,
	output apt_pkg::row_prod_t       prod_s2
);

	apt_pkg::coef_t  c0, c1, c2;
	apt_pkg::coord_t x, y, z;
	apt_pkg::prod_t  p0, p1, p2;

	assign c0 = coef.c0;
	assign c1 = coef.c1;
	assign c2 = coef.c2;
	assign x  = pt.in_x;
	assign y  = pt.in_y;
	assign z  = pt.in_z;

	// Signed 32x32 products at full precision
	assign p0 = c0 * x;
	assign p1 = c1 * y;
	assign p2 = c2 * z;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2.p0 <= p0;
			prod_s2.p1 <= p1;
			prod_s2.p2 <= p2;
		end
	end

endmodule
`default_nettype wire

### rtl/apt_row_sum.sv
`default_nettype none
module apt_row_sum (
	input  wire apt_pkg::row_prod_t  prod,
	input  wire apt_pkg::coef_t      tr,
	output apt_pkg::coord_t          coord,
	output logic                     sat
);

	localparam int TOP_BITS = apt_pkg::ACC_BITS - apt_pkg::COORD_BITS + 1;

	apt_pkg::prod_t p0, p1, p2;
	apt_pkg::acc_t  tr_ext;
	apt_pkg::acc_t  acc;
	apt_pkg::acc_t  shifted;
	logic [TOP_BITS-1:0] top;

	assign p0     = prod.p0;
	assign p1     = prod.p1;
	assign p2     = prod.p2;
	assign tr_ext = apt_pkg::ACC_BITS'(tr) <<< apt_pkg::FRAC_BITS;

	// Round half up, then floor-shift
	assign acc = apt_pkg::ACC_BITS'(p0) + apt_pkg::ACC_BITS'(p1) + apt_pkg::ACC_BITS'(p2)
		+ tr_ext + apt_pkg::ROUND_HALF;
	assign shifted = acc >>> apt_pkg::FRAC_BITS;

	// In range when all bits above the output sign match it
	assign top = shifted[apt_pkg::ACC_BITS-1:apt_pkg::COORD_BITS-1];

	always_comb begin
		if ((&top) || !(|top)) begin
			coord = shifted[apt_pkg::COORD_BITS-1:0];
			sat   = 1'b0;
		end else begin
			coord = shifted[apt_pkg::ACC_BITS-1] ? apt_pkg::COORD_MIN : apt_pkg::COORD_MAX;
			sat   = 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/affine_point_transform_core.sv
`default_nettype none
// Affine point transform: takes one signed Q16.16 point (x, y, z) per item and
// returns it multiplied by the upper three rows of a 4x4 affine matrix, each
// coordinate rounded half up to Q16.16 and saturated to 32 bits; saturated
// flags a clipped coordinate and last_out copies last_in. The block takes one
// item every clock while point_stall is low; an accepted item passes three
// registers: an input register, a product register after the nine 32x32
// multipliers, and the result register after the three-way accumulate,
// round and clip. The stages advance independently, so bubbles collapse and
// the block keeps accepting while results wait; point_stall rises only when
// all three stages hold items. The matrix lives in six 64-bit registers at
// byte addresses 0x00..0x28 (two Q16.16 coefficients each, even column low),
// resetting to identity; write them only while no items are in flight.
module affine_point_transform_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                point_valid,
	output logic                                     point_stall,
	input  wire apt_pkg::point_t                     point,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output apt_pkg::result_t                         result,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [apt_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  wire logic [apt_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic      [apt_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                     pready
);

	apt_pkg::matrix_t matrix;

	// Stage valids and advance enables
	logic vld_s1, vld_s2, result_valid_q;
	logic adv_s1, adv_s2, adv_out;

	apt_pkg::point_t    point_s1;
	logic               last_s2;
	apt_pkg::row_prod_t prod_s2 [apt_pkg::NUM_ROWS];
	apt_pkg::coord_t    coord   [apt_pkg::NUM_ROWS];
	logic               row_sat [apt_pkg::NUM_ROWS];
	apt_pkg::result_t   result_q;

	apt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.matrix  (matrix)
	);

	// A stage advances when it is empty or the stage after it moves on
	assign adv_out     = !result_valid_q || !result_stall;
	assign adv_s2      = !vld_s2 || adv_out;
	assign adv_s1      = !vld_s1 || adv_s2;
	assign point_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= point_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_out) begin
				result_valid_q <= vld_s2;
			end
		end
	end

	// Input register: capture the item on acceptance
	always_ff @(posedge clk) begin
		if (adv_s1 && point_valid) begin
			point_s1 <= point;
		end
	end

	// Batch marker rides along with the products
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			last_s2 <= point_s1.last_in;
		end
	end

	// One multiply row and one accumulate row per output coordinate
	for (genvar r = 0; r < apt_pkg::NUM_ROWS; r++) begin : g_row
		apt_row_mul u_mul (
			.clk     (clk),
			.load    (adv_s2 && vld_s1),
			.coef    (matrix[r]),
			.pt      (point_s1),
			.prod_s2 (prod_s2[r])
		);

		apt_row_sum u_sum (
			.prod  (prod_s2[r]),
			.tr    (matrix[r].tr),
			.coord (coord[r]),
			.sat   (row_sat[r])
		);
	end

	// Result register: hold while the consumer stalls
	always_ff @(posedge clk) begin
		if (adv_out && vld_s2) begin
			result_q.out_x     <= coord[0];
			result_q.out_y     <= coord[1];
			result_q.out_z     <= coord[2];
			result_q.saturated <= row_sat[0] || row_sat[1] || row_sat[2];
			result_q.last_out  <= last_s2;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A stalled product stage keeps its item
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !adv_out) |=> vld_s2)
		else $error("product stage lost an item while the output stalled");

	// An item leaving the input register lands in the product stage
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && adv_s2) |=> vld_s2)
		else $error("item dropped between input and product stages");

	// Back-pressure only with every stage occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> (vld_s1 && vld_s2 && result_valid_q && result_stall))
		else $error("input stalled with a free pipeline stage");

endmodule
`default_nettype wire
